@@ sv/srp_pkg.sv @@
// Package with the shared types and codes of the shelf rectangle packer.
package srp_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DIM = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PADDING = 1'b1;

  localparam logic [15:0] MaxDimReset = 16'd4096;
  localparam logic [7:0] PaddingReset = 8'd0;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } srp_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_NEW,
    S_DONE
  } srp_state_e;

  typedef struct packed {
    logic        action;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
  } srp_in_t;

  typedef struct packed {
    srp_status_e status;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] used_width;
    logic [15:0] used_height;
  } srp_out_t;

  typedef struct packed {
    logic [16:0] cursor;
    logic [16:0] tall;
    logic [16:0] top;
  } srp_shelf_t;

  typedef struct packed {
    logic load;
    logic start;
    logic scan;
    logic place_new;
    logic clear;
    logic emit;
  } srp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_empty;
    logic hit;
    logic last;
    logic out_free;
  } srp_sts_t;

endpackage

@@ sv/shelf_rectangle_packer.sv @@
// Top level of the shelf rectangle packer: controller and datapath.
// One transaction at a time. A place transaction walks the open shelves first-fit from shelf 0
// and opens a new shelf if none fits, or fails if the new shelf does not fit or none is free;
// the first-fit walk reads one shelf entry per cycle from the shelf memory. A place transaction
// on an empty atlas goes to a new shelf without a walk, and a clear needs no walk. A result
// held in the output register does not block acceptance of the next transaction; a result
// is delayed only while the previous one is still stalled.
module shelf_rectangle_packer #(
  parameter int unsigned MAX_SHELVES = 32,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  srp_pkg::srp_in_t             in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output srp_pkg::srp_out_t            out_o,
  input  logic                         cfg_we_i,
  input  logic [srp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [srp_pkg::CfgDataW-1:0] cfg_data_i
);

  srp_pkg::srp_cmd_t cmd;
  srp_pkg::srp_sts_t sts;

  srp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srp_datapath #(
    .MAX_SHELVES (MAX_SHELVES),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

@@ sv/srp_ctrl.sv @@
// Controller state machine that sequences the shelf walk of the packer.
module srp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  srp_pkg::srp_sts_t sts_i,
  output srp_pkg::srp_cmd_t cmd_o
);

  srp_pkg::srp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      srp_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = srp_pkg::S_DISPATCH;
        end
      end
      srp_pkg::S_DISPATCH: begin
        priority if (sts_i.is_clear) begin
          cmd_o.clear = 1'b1;
          state_d     = srp_pkg::S_DONE;
        end else if (sts_i.is_empty) begin
          state_d = srp_pkg::S_NEW;
        end else begin
          cmd_o.start = 1'b1;
          state_d     = srp_pkg::S_SCAN;
        end
      end
      srp_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        priority if (sts_i.hit) begin
          state_d = srp_pkg::S_DONE;
        end else if (sts_i.last) begin
          state_d = srp_pkg::S_NEW;
        end
      end
      srp_pkg::S_NEW: begin
        cmd_o.place_new = 1'b1;
        state_d         = srp_pkg::S_DONE;
      end
      srp_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = srp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = srp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/srp_datapath.sv @@
// Datapath of the packer: shelf memory, atlas registers, fit tests and output register.
module srp_datapath #(
  parameter int unsigned MAX_SHELVES = 32,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  srp_pkg::srp_in_t               in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output srp_pkg::srp_out_t              out_o,
  input  logic                           cfg_we_i,
  input  logic [srp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [srp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  srp_pkg::srp_cmd_t              cmd_i,
  output srp_pkg::srp_sts_t              sts_o
);

  localparam int unsigned IW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int unsigned CW = $clog2(MAX_SHELVES + 1);
  localparam logic [24:0] CoordMax = 25'((64'd1 << COORD_BITS) - 64'd1);

  function automatic logic [15:0] sat_used(logic [16:0] v);
    logic [24:0] wide;
    wide = {8'd0, v};
    if (wide > CoordMax) begin
      return CoordMax[15:0];
    end
    return v[15:0];
  endfunction

  srp_pkg::srp_shelf_t mem [MAX_SHELVES];
  srp_pkg::srp_shelf_t rd_q;
  srp_pkg::srp_shelf_t mem_wdata;
  logic [IW-1:0]       mem_waddr;
  logic [IW-1:0]       raddr;
  logic                mem_we;
  logic                mem_re;

  logic [15:0] max_q;
  logic [7:0]  pad_q;
  logic        act_q;
  logic [15:0] w_q;
  logic [15:0] h_q;
  logic [16:0] wpad_q;
  logic [16:0] hpad_q;
  logic [CW-1:0] count_q;
  logic [16:0]   total_q;
  logic [16:0]   widest_q;
  logic [IW-1:0] idx_q;
  srp_pkg::srp_status_e res_status_q;
  logic [15:0] res_x_q;
  logic [15:0] res_y_q;
  logic        out_valid_q;
  srp_pkg::srp_out_t out_q;

  logic [18:0] sum_cur;
  logic [18:0] sum_tall;
  logic        hit;
  logic        last;
  logic        empty;
  logic        full;
  logic        new_fit;
  logic        new_ok;
  logic        out_free;

  always_comb begin
    sum_cur  = 19'(rd_q.cursor) + 19'(wpad_q);
    sum_tall = 19'(total_q) + 19'(hpad_q);
    hit      = ({1'b0, h_q} <= rd_q.tall) && (sum_cur <= 19'(max_q));
    last     = (CW'(idx_q) + CW'(1)) == count_q;
    empty    = count_q == '0;
    full     = count_q == CW'(MAX_SHELVES);
    if (empty) begin
      new_fit = (w_q <= max_q) && (h_q <= max_q);
    end else begin
      new_fit = (sum_tall <= 19'(max_q)) && (w_q <= max_q);
    end
    new_ok   = new_fit && !full;
    out_free = !out_valid_q || !out_stall_i;

    mem_re = cmd_i.start || cmd_i.scan;
    raddr  = cmd_i.start ? '0 : idx_q + IW'(1);
    mem_we = (cmd_i.scan && hit) || (cmd_i.place_new && new_ok);
    if (cmd_i.scan) begin
      mem_waddr        = idx_q;
      mem_wdata.cursor = sum_cur[16:0];
      mem_wdata.tall   = rd_q.tall;
      mem_wdata.top    = rd_q.top;
    end else begin
      mem_waddr        = count_q[IW-1:0];
      mem_wdata.cursor = wpad_q;
      mem_wdata.tall   = hpad_q;
      mem_wdata.top    = total_q;
    end

    sts_o.is_clear = act_q;
    sts_o.is_empty = empty;
    sts_o.hit      = hit;
    sts_o.last     = last;
    sts_o.out_free = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= srp_pkg::MaxDimReset;
      pad_q       <= srp_pkg::PaddingReset;
      act_q       <= 1'b0;
      count_q     <= '0;
      total_q     <= '0;
      widest_q    <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          srp_pkg::CFG_MAX_DIM: max_q <= cfg_data_i;
          srp_pkg::CFG_PADDING: pad_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        act_q <= in_i.action;
      end
      if (cmd_i.start) begin
        idx_q <= '0;
      end
      if (cmd_i.scan) begin
        if (hit) begin
          if (sum_cur[16:0] > widest_q) begin
            widest_q <= sum_cur[16:0];
          end
        end else if (!last) begin
          idx_q <= idx_q + IW'(1);
        end
      end
      if (cmd_i.place_new && new_ok) begin
        count_q <= count_q + CW'(1);
        total_q <= sum_tall[16:0];
        if (wpad_q > widest_q) begin
          widest_q <= wpad_q;
        end
      end
      if (cmd_i.clear) begin
        count_q  <= '0;
        total_q  <= '0;
        widest_q <= '0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q    <= in_i.rect_width;
      h_q    <= in_i.rect_height;
      wpad_q <= 17'(in_i.rect_width) + 17'(pad_q);
      hpad_q <= 17'(in_i.rect_height) + 17'(pad_q);
    end
    if (cmd_i.scan && hit) begin
      res_status_q <= srp_pkg::ST_PLACED;
      res_x_q      <= rd_q.cursor[15:0];
      res_y_q      <= rd_q.top[15:0];
    end
    if (cmd_i.place_new) begin
      res_x_q <= '0;
      priority if (!new_fit) begin
        res_status_q <= srp_pkg::ST_NOFIT;
        res_y_q      <= '0;
      end else if (full) begin
        res_status_q <= srp_pkg::ST_FULL;
        res_y_q      <= '0;
      end else begin
        res_status_q <= srp_pkg::ST_PLACED;
        res_y_q      <= total_q[15:0];
      end
    end
    if (cmd_i.clear) begin
      res_status_q <= srp_pkg::ST_CLEARED;
      res_x_q      <= '0;
      res_y_q      <= '0;
    end
    if (cmd_i.emit) begin
      out_q.status      <= res_status_q;
      out_q.pos_x       <= res_x_q;
      out_q.pos_y       <= res_y_q;
      out_q.used_width  <= sat_used(widest_q);
      out_q.used_height <= sat_used(total_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ sv/srp_checker.sv @@
// Port-level checker for the shelf rectangle packer and its bind statement.
module srp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input srp_pkg::srp_out_t out_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a transaction is in flight");

  a_pos_zero_unless_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status != srp_pkg::ST_PLACED) |->
      (out_o.pos_x == 16'd0 && out_o.pos_y == 16'd0))
    else $error("position reported for a rectangle that was not placed");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status == srp_pkg::ST_CLEARED) |->
      (out_o.used_width == 16'd0 && out_o.used_height == 16'd0))
    else $error("clear reported a nonzero atlas size");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_o)))
    else $error("stalled result changed or dropped");

endmodule

bind shelf_rectangle_packer srp_checker u_srp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
